@@ hw/rtl/swing_trigger_scheduler_assert.svh @@
// Assertion macros shared by the checker of swing_trigger_scheduler.
// Expects signals clk and rst_n in the scope of each use.
`ifndef SWING_TRIGGER_SCHEDULER_ASSERT_SVH
`define SWING_TRIGGER_SCHEDULER_ASSERT_SVH

// Same-cycle implication, checked out of reset only.
`define STS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sts assertion failed");

// Next-cycle implication, checked out of reset only.
`define STS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sts assertion failed");

`endif

@@ hw/rtl/sts_pkg.sv @@
// Shared types, constants and helper functions of the swing trigger scheduler.
// No dependencies; used by every module of the block.
package sts_pkg;

  localparam int CHANNELS        = 12;
  localparam int GROUP_SIZE      = 6;
  localparam int SWUNG_CHANNELS  = 5;
  localparam int PROFILE_COUNT   = 8;
  localparam int DEFAULT_PROFILE = 3;
  localparam int NO_SWING_PCT    = 50;

  localparam int CH_W    = 4;
  localparam int PROF_W  = 3;
  localparam int TIME_W  = 32;
  localparam int PULSE_W = 10;
  localparam int TEMPO_W = 16;
  localparam int DIFF_W  = 6;
  localparam int PROD_W  = 22;
  localparam int MUL_W   = 23;
  localparam int DELAY_W = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // x / 100 == (x * RECIP) >> RECIP_SHIFT for every x below 2^PROD_W
  localparam int RECIP_SHIFT = 29;
  localparam logic [MUL_W-1:0] RECIP = 23'd5368710;

  localparam logic [PULSE_W-1:0] PULSE_RESET = 10'd10;
  localparam logic [PROF_W-1:0]  PROF_RESET  = PROF_W'(DEFAULT_PROFILE % PROFILE_COUNT);

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_PULSE  = 2'd0;
  localparam logic [1:0] REG_PROF_A = 2'd1;
  localparam logic [1:0] REG_PROF_B = 2'd2;

  // Swing percent, row = profile, column = swung channel slot
  localparam logic [6:0] SWING_TABLE [8][5] = '{
    '{7'd50, 7'd50, 7'd50, 7'd50, 7'd50},
    '{7'd52, 7'd53, 7'd54, 7'd55, 7'd56},
    '{7'd55, 7'd57, 7'd59, 7'd61, 7'd63},
    '{7'd58, 7'd61, 7'd64, 7'd67, 7'd70},
    '{7'd62, 7'd65, 7'd68, 7'd71, 7'd74},
    '{7'd66, 7'd69, 7'd72, 7'd75, 7'd78},
    '{7'd70, 7'd73, 7'd76, 7'd79, 7'd82},
    '{7'd75, 7'd78, 7'd81, 7'd84, 7'd87}
  };

  typedef struct packed {
    logic [TIME_W-1:0]  now_ms;
    logic               profile_step;
    logic               clock_edge;
    logic [TIME_W-1:0]  edge_count;
    logic [TEMPO_W-1:0] beat_interval_ms;
  } in_t;

  typedef struct packed {
    logic [CHANNELS-1:0] jack_levels;
    logic [PROF_W-1:0]   profile_a_now;
    logic [PROF_W-1:0]   profile_b_now;
  } out_t;

  typedef struct packed {
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_at;
    logic              level;
  } chan_t;

  // Swing excess over straight time, zero on even beats and unswung channels
  function automatic logic [DIFF_W-1:0] swing_diff(input logic [PROF_W-1:0] prof,
                                                  input logic [CH_W-1:0] pos,
                                                  input logic odd_beat);
    logic [CH_W-1:0] slot;
    logic [6:0]      pct;
    slot = pos - CH_W'(1);
    pct  = '0;
    if (odd_beat && pos >= CH_W'(1) && pos <= CH_W'(SWUNG_CHANNELS)) begin
      pct = SWING_TABLE[prof][slot[2:0]];
      return DIFF_W'(pct - 7'(NO_SWING_PCT));
    end
    return '0;
  endfunction

  function automatic logic [PROF_W-1:0] prof_up(input logic [PROF_W-1:0] p);
    logic [PROF_W:0] inc;
    inc = {1'b0, p} + (PROF_W+1)'(1);
    return (inc == (PROF_W+1)'(PROFILE_COUNT)) ? '0 : inc[PROF_W-1:0];
  endfunction

  function automatic logic [PROF_W-1:0] prof_down(input logic [PROF_W-1:0] p);
    return (p == '0) ? PROF_W'(PROFILE_COUNT - 1) : p - PROF_W'(1);
  endfunction

  function automatic logic [PROF_W-1:0] prof_load(input logic [PROF_W-1:0] v);
    return ({1'b0, v} < (PROF_W+1)'(PROFILE_COUNT)) ? v : PROF_RESET;
  endfunction

endpackage

@@ hw/rtl/sts_mul_unit.sv @@
// Shared multiplier of the scheduler: tempo scaling, then divide by 100
// through a reciprocal. Depends on sts_pkg.
module sts_mul_unit import sts_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic               first,
  input  logic [DIFF_W-1:0]  diff,
  input  logic [TEMPO_W-1:0] tempo,
  output logic [DELAY_W-1:0] delay
);

  logic [MUL_W-1:0]   op_a;
  logic [MUL_W-1:0]   op_b;
  logic [2*MUL_W-1:0] prod_r;

  // First pass: excess percent times tempo. Second pass: scale by 1/100.
  assign op_a  = first ? MUL_W'(diff)  : MUL_W'(prod_r[PROD_W-1:0]);
  assign op_b  = first ? MUL_W'(tempo) : RECIP;
  assign delay = prod_r[RECIP_SHIFT +: DELAY_W];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule

@@ hw/rtl/sts_chan_unit.sv @@
// Per-channel update logic, shared by all twelve channels in turn:
// fire/release pass, or the schedule pass. Depends on sts_pkg.
module sts_chan_unit import sts_pkg::*; (
  input  logic               sched,
  input  logic               sched_en,
  input  chan_t              cur,
  input  logic [TIME_W-1:0]  now,
  input  logic [PULSE_W-1:0] pulse,
  input  logic [DELAY_W-1:0] delay,
  output chan_t              nxt
);

  logic [TIME_W-1:0] t_off;
  logic [TIME_W-1:0] t_on;
  chan_t             mid;

  assign t_off = now + TIME_W'(pulse);
  assign t_on  = now + TIME_W'(delay);

  always_comb begin
    mid = cur;
    nxt = cur;
    if (!sched) begin
      // fire a due ON time unless a pulse is still running
      if (cur.on_time != '0 && now >= cur.on_time) begin
        if (cur.off_at == '0) begin
          mid.level  = 1'b1;
          mid.off_at = t_off;
        end
        mid.on_time = '0;
      end
      // release an expired OFF time
      nxt = mid;
      if (mid.off_at != '0 && now >= mid.off_at) begin
        nxt.level  = 1'b0;
        nxt.off_at = '0;
      end
    end else if (sched_en && cur.off_at == '0 && cur.on_time == '0) begin
      if (delay == '0) begin
        nxt.level  = 1'b1;
        nxt.off_at = t_off;
      end else begin
        nxt.on_time = t_on;
      end
    end
  end

endmodule

@@ hw/rtl/swing_trigger_scheduler.sv @@
// Swing trigger scheduler, top level; uses sts_pkg, sts_mul_unit, sts_chan_unit.
// One request at a time: in_ready is low from acceptance until the result is
// registered, which can wait on out_ready; the 12 channels are visited in turn,
// each in states EVT, MUL and SCHED, with two passes through the shared multiplier.
// Reset (rst_n low, synchronous): all slots empty, levels low, profiles 3, pulse 10 ms.
module swing_trigger_scheduler import sts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  // Per channel: EVT runs fire/release and starts the multiply, MUL scales the
  // product by 1/100, SCHED schedules the channel on a clock edge.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVT,
    S_MUL,
    S_SCHED,
    S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  in_t                 req_r;
  logic [PROF_W-1:0]   prof_a_r, prof_a_nxt;
  logic [PROF_W-1:0]   prof_b_r, prof_b_nxt;
  logic [PULSE_W-1:0]  pulse_r, pulse_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic [TIME_W-1:0]   on_r  [CHANNELS];
  logic [TIME_W-1:0]   off_r [CHANNELS];
  logic [CHANNELS-1:0] lvl_r;

  logic                in_acc;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;
  logic                grp_b;
  logic [CH_W-1:0]     ch_pos;
  logic [PROF_W-1:0]   prof_sel;
  logic [DIFF_W-1:0]   diff;
  logic [DELAY_W-1:0]  delay;
  logic                mul_en;
  logic                mul_first;
  logic                chan_we;
  chan_t               chan_cur;
  chan_t               chan_nxt;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Read back the registers; unknown indexes read zero
  always_comb begin
    unique case (cfg_idx)
      REG_PULSE:  cfg_prdata = DATA_W'(pulse_r);
      REG_PROF_A: cfg_prdata = DATA_W'(prof_a_r);
      REG_PROF_B: cfg_prdata = DATA_W'(prof_b_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // Channel position within its group and the group's profile
  assign grp_b    = (ch_r >= CH_W'(GROUP_SIZE));
  assign ch_pos   = grp_b ? ch_r - CH_W'(GROUP_SIZE) : ch_r;
  assign prof_sel = grp_b ? prof_b_r : prof_a_r;
  // beat = (count - 1) mod 4 is odd exactly when the count is even
  assign diff     = swing_diff(prof_sel, ch_pos, ~req_r.edge_count[0]);

  assign chan_cur = '{on_time: on_r[ch_r], off_at: off_r[ch_r], level: lvl_r[ch_r]};

  sts_mul_unit u_mul (
    .clk   (clk),
    .en    (mul_en),
    .first (mul_first),
    .diff  (diff),
    .tempo (req_r.beat_interval_ms),
    .delay (delay)
  );

  sts_chan_unit u_chan (
    .sched    (state_r == S_SCHED),
    .sched_en (req_r.clock_edge),
    .cur      (chan_cur),
    .now      (req_r.now_ms),
    .pulse    (pulse_r),
    .delay    (delay),
    .nxt      (chan_nxt)
  );

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    prof_a_nxt    = prof_a_r;
    prof_b_nxt    = prof_b_r;
    pulse_nxt     = pulse_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_en        = 1'b0;
    mul_first     = 1'b0;
    chan_we       = 1'b0;

    // drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // the user must issue configuration writes only while idle; the block does not enforce it
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PULSE:  pulse_nxt  = cfg_pwdata[PULSE_W-1:0];
        REG_PROF_A: prof_a_nxt = prof_load(cfg_pwdata[PROF_W-1:0]);
        REG_PROF_B: prof_b_nxt = prof_load(cfg_pwdata[PROF_W-1:0]);
        default:    ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // step profiles before any channel is visited
          if (in_data.profile_step) begin
            prof_a_nxt = prof_up(prof_a_r);
            prof_b_nxt = prof_down(prof_b_r);
          end
          ch_nxt    = '0;
          state_nxt = S_EVT;
        end
      end
      S_EVT: begin
        chan_we   = 1'b1;
        mul_en    = 1'b1;
        mul_first = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        mul_en    = 1'b1;
        state_nxt = S_SCHED;
      end
      S_SCHED: begin
        chan_we = 1'b1;
        if (ch_r == CH_W'(CHANNELS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          ch_nxt    = ch_r + CH_W'(1);
          state_nxt = S_EVT;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{jack_levels: lvl_r, profile_a_now: prof_a_r,
                            profile_b_now: prof_b_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      prof_a_r    <= PROF_RESET;
      prof_b_r    <= PROF_RESET;
      pulse_r     <= PULSE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      prof_a_r    <= prof_a_nxt;
      prof_b_r    <= prof_b_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      req_r <= in_data;
    end
  end

  // Channel slots and levels: zero means no event pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        on_r[i]  <= '0;
        off_r[i] <= '0;
      end
      lvl_r <= '0;
    end else if (chan_we) begin
      on_r[ch_r]  <= chan_nxt.on_time;
      off_r[ch_r] <= chan_nxt.off_at;
      lvl_r[ch_r] <= chan_nxt.level;
    end
  end

endmodule

@@ hw/rtl/sts_checker.sv @@
// Port-level checker of swing_trigger_scheduler and its bind.
// Depends on sts_pkg and swing_trigger_scheduler_assert.svh.
`include "swing_trigger_scheduler_assert.svh"

module sts_checker import sts_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data,
  input logic cfg_pready
);

  // a stalled result holds
  `STS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // the block is busy right after taking a request
  `STS_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)
  // profiles reported stay within the profile count
  `STS_ASSERT_IMP(a_prof_range, out_valid,
    ({1'b0, out_data.profile_a_now} < (PROF_W+1)'(PROFILE_COUNT)) &&
    ({1'b0, out_data.profile_b_now} < (PROF_W+1)'(PROFILE_COUNT)))
  // the configuration port never waits
  `STS_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_pready)

endmodule

bind swing_trigger_scheduler sts_checker u_sts_checker (.*);
